// ===== hw/rtl/ffs_pkg.sv =====
`default_nettype none

package ffs_pkg;

  // hold sizing
  localparam int HoldBytes  = 32;
  localparam int MaxResults = 32;
  localparam int HoldCap    = (HoldBytes < MaxResults) ? HoldBytes : MaxResults;
  localparam int BufAw      = $clog2(HoldCap);
  localparam int BufDepth   = 1 << BufAw;
  localparam int CntW       = $clog2(HoldCap + 1);

  // length handling
  localparam int LenW = 21;
  localparam int ProdW = LenW + 4;
  localparam logic [LenW-1:0] CapLimit = LenW'(1 << 20);
  localparam logic [LenW-1:0] TrailerLen = LenW'(7);

  // header pattern "8=FIX.4.4" SOH "9="
  localparam int PatLen = 12;
  localparam int MpW    = 4;
  localparam logic [7:0] Soh = 8'h01;

  // framing phases
  localparam int PhW = 2;
  localparam logic [PhW-1:0] PhHunt   = 2'd0;
  localparam logic [PhW-1:0] PhDigits = 2'd1;
  localparam logic [PhW-1:0] PhBody   = 2'd2;

  typedef struct packed {
    logic load;     // write accepted byte into buffer
    logic step;     // process byte at queue head
    logic rel_pop;  // release one held byte
    logic rd_rel;   // read from hold base instead of queue head
    logic flush;    // send pending result as last of the run
  } ffs_cmd_t;

  typedef struct packed {
    logic q_empty;
    logic scan_emit;
    logic scan_rel;
    logic rel_done;
    logic out_free;
    logic pend_v;
  } ffs_sts_t;

  function automatic logic [7:0] hdr_pat(input logic [MpW-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h38;
      4'd1:    c = 8'h3D;
      4'd2:    c = 8'h46;
      4'd3:    c = 8'h49;
      4'd4:    c = 8'h58;
      4'd5:    c = 8'h2E;
      4'd6:    c = 8'h34;
      4'd7:    c = 8'h2E;
      4'd8:    c = 8'h34;
      4'd9:    c = Soh;
      4'd10:   c = 8'h39;
      4'd11:   c = 8'h3D;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fix_frame_splitter.sv =====
`default_nettype none

// FIX 4.4 frame splitter: one received byte per input transaction.
// Input channel (in_valid_i / in_stall_o / in_byte_i) carries the session
// stream; output channel (out_valid_o / out_stall_i) carries frame bytes
// with frame_first_o on the leading '8', frame_last_o on the final trailer
// byte, and run_last_o on the last result caused by one input byte.
// The cfg channel writes max_body_len (values above 2^20 saturate); write it
// only while the block is idle. cfg_ready_o is always high.
// A byte is taken while the block is idle, then scanned, and the run is
// then closed with a flush of any pending result. A valid header release
// sends out the held bytes one by one; a resync rescans the held bytes
// one per cycle; the single read port of the hold buffer sets this pace.
// The first result of a run waits in the pending stage before output.
// Reset clears the framing state and empties the hold buffer; the length
// cap returns to 2^20. A stalled receiver holds the output register and the
// block waits with in_stall_o high until its results drain.
module fix_frame_splitter (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [ffs_pkg::LenW-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               in_byte_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [7:0]               out_byte_o,
  output logic                     frame_first_o,
  output logic                     frame_last_o,
  output logic                     run_last_o
);
  import ffs_pkg::*;

  ffs_cmd_t cmd;
  ffs_sts_t sts;

  assign cfg_ready_o = 1'b1;

  // sequencer
  ffs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // buffer, framing state and output stage
  ffs_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .in_byte_i     (in_byte_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .frame_first_o (frame_first_o),
    .frame_last_o  (frame_last_o),
    .run_last_o    (run_last_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/ffs_ctrl.sv =====
`default_nettype none

module ffs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ffs_pkg::ffs_sts_t sts_i,
  output ffs_pkg::ffs_cmd_t cmd_o
);
  import ffs_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StRel  = 2'd2;

  logic [1:0] state_q, state_d;

  // sequencing of load, scan, release and end-of-run flush
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StScan;
        end
      end
      StScan: begin
        if (sts_i.q_empty) begin
          if (!sts_i.pend_v) begin
            state_d = StIdle;
          end else if (sts_i.out_free) begin
            cmd_o.flush = 1'b1;
            state_d     = StIdle;
          end
        end else if (!sts_i.scan_emit || sts_i.out_free) begin
          cmd_o.step = 1'b1;
          if (sts_i.scan_rel) begin
            state_d = StRel;
          end
        end
      end
      StRel: begin
        cmd_o.rd_rel = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.rel_pop = 1'b1;
          if (sts_i.rel_done) begin
            state_d = StScan;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

endmodule

`default_nettype wire

// ===== hw/rtl/ffs_dp.sv =====
`default_nettype none

module ffs_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic [ffs_pkg::LenW-1:0]   cfg_data_i,
  input  logic [7:0]                 in_byte_i,
  input  ffs_pkg::ffs_cmd_t          cmd_i,
  output ffs_pkg::ffs_sts_t          sts_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [7:0]                 out_byte_o,
  output logic                       frame_first_o,
  output logic                       frame_last_o,
  output logic                       run_last_o
);
  import ffs_pkg::*;

  // byte buffer: held prefix followed by bytes still to scan
  logic [7:0]       buf_q [BufDepth];
  logic [BufAw-1:0] bp_q, bp_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  hc_q, hc_d;

  // framing state
  logic [PhW-1:0]   phase_q, phase_d;
  logic [MpW-1:0]   mp_q, mp_d;
  logic [LenW-1:0]  acc_q, acc_d;
  logic [LenW-1:0]  rem_q, rem_d;
  logic             rel_first_q, rel_first_d;
  logic [LenW-1:0]  max_len_q;

  // pending result and output register
  logic             pend_v_q, pend_v_d;
  logic [7:0]       pend_byte_q;
  logic             pend_first_q, pend_last_q;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q;
  logic             out_first_q, out_last_q, out_run_last_q;

  logic [BufAw-1:0] rd_addr;
  logic [7:0]       cur;
  logic             is_digit;
  logic [3:0]       dval;
  logic [ProdW-1:0] prod;
  logic             hunt_ok, soh_ok, dig_ok, out_free;
  logic             emit_v, emit_first, emit_last;

  // single read port: hold base during release, queue head otherwise
  assign rd_addr = cmd_i.rd_rel ? bp_q : bp_q + hc_q[BufAw-1:0];
  assign cur     = buf_q[rd_addr];

  // byte classification
  assign is_digit = (cur >= 8'h30) && (cur <= 8'h39);
  assign dval     = 4'(cur - 8'h30);
  assign prod     = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + ProdW'(dval);
  assign hunt_ok  = (mp_q < MpW'(PatLen)) && (cur == hdr_pat(mp_q)) &&
                    (hc_q < CntW'(HoldCap));
  assign soh_ok   = (hc_q > CntW'(PatLen)) && (hc_q < CntW'(HoldCap));
  assign dig_ok   = (prod <= {4'b0, max_len_q}) &&
                    (({1'b0, hc_q} + 1'b1) < (CntW + 1)'(HoldCap));

  assign out_free = !out_valid_q || !out_stall_i;

  // status to controller
  always_comb begin
    sts_o           = '0;
    sts_o.q_empty   = (cnt_q == hc_q);
    sts_o.scan_emit = (phase_q == PhBody);
    sts_o.scan_rel  = (phase_q == PhDigits) && (cur == Soh) && soh_ok;
    sts_o.rel_done  = (hc_q == CntW'(1));
    sts_o.out_free  = out_free;
    sts_o.pend_v    = pend_v_q;
  end

  // next state of buffer pointers and framing state
  always_comb begin
    logic fail;
    fail        = 1'b0;
    bp_d        = bp_q;
    cnt_d       = cnt_q;
    hc_d        = hc_q;
    phase_d     = phase_q;
    mp_d        = mp_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    rel_first_d = rel_first_q;
    emit_v      = 1'b0;
    emit_first  = 1'b0;
    emit_last   = 1'b0;

    if (cmd_i.load) begin
      cnt_d = cnt_q + 1'b1;
    end

    if (cmd_i.step) begin
      unique case (phase_q)
        PhBody: begin
          emit_v    = 1'b1;
          emit_last = (rem_q <= LenW'(1));
          bp_d      = bp_q + 1'b1;
          cnt_d     = cnt_q - 1'b1;
          if (rem_q <= LenW'(1)) begin
            rem_d   = '0;
            phase_d = PhHunt;
            mp_d    = '0;
            acc_d   = '0;
          end else begin
            rem_d = rem_q - 1'b1;
          end
        end
        PhHunt: begin
          if (hunt_ok) begin
            hc_d = hc_q + 1'b1;
            mp_d = mp_q + 1'b1;
            if (mp_q == MpW'(PatLen - 1)) begin
              phase_d = PhDigits;
            end
          end else begin
            fail = 1'b1;
          end
        end
        PhDigits: begin
          if (cur == Soh) begin
            if (soh_ok) begin
              hc_d        = hc_q + 1'b1;
              rem_d       = acc_q + TrailerLen;
              phase_d     = PhBody;
              mp_d        = '0;
              acc_d       = '0;
              rel_first_d = 1'b1;
            end else begin
              fail = 1'b1;
            end
          end else if (is_digit && dig_ok) begin
            hc_d  = hc_q + 1'b1;
            acc_d = prod[LenW-1:0];
          end else begin
            fail = 1'b1;
          end
        end
        default: begin
          fail = 1'b1;
        end
      endcase
    end

    // resync: drop the oldest buffered byte and rescan the rest
    if (fail) begin
      bp_d    = bp_q + 1'b1;
      cnt_d   = cnt_q - 1'b1;
      hc_d    = '0;
      phase_d = PhHunt;
      mp_d    = '0;
      acc_d   = '0;
    end

    // release of the held prefix, one byte per transaction
    if (cmd_i.rel_pop) begin
      emit_v      = 1'b1;
      emit_first  = rel_first_q;
      rel_first_d = 1'b0;
      bp_d        = bp_q + 1'b1;
      cnt_d       = cnt_q - 1'b1;
      hc_d        = hc_q - 1'b1;
    end
  end

  // one-deep pending stage so run_last is known when a result leaves
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    pend_v_d    = pend_v_q;
    if (emit_v) begin
      pend_v_d = 1'b1;
      if (pend_v_q) begin
        out_valid_d = 1'b1;
      end
    end
    if (cmd_i.flush) begin
      pend_v_d    = 1'b0;
      out_valid_d = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bp_q        <= '0;
      cnt_q       <= '0;
      hc_q        <= '0;
      phase_q     <= PhHunt;
      mp_q        <= '0;
      acc_q       <= '0;
      rem_q       <= '0;
      rel_first_q <= 1'b0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      max_len_q   <= CapLimit;
    end else begin
      bp_q        <= bp_d;
      cnt_q       <= cnt_d;
      hc_q        <= hc_d;
      phase_q     <= phase_d;
      mp_q        <= mp_d;
      acc_q       <= acc_d;
      rem_q       <= rem_d;
      rel_first_q <= rel_first_d;
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        max_len_q <= (cfg_data_i > CapLimit) ? CapLimit : cfg_data_i;
      end
    end
  end

  // buffer write
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      buf_q[bp_q + cnt_q[BufAw-1:0]] <= in_byte_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (emit_v) begin
      pend_byte_q  <= cur;
      pend_first_q <= emit_first;
      pend_last_q  <= emit_last;
    end
    if ((emit_v && pend_v_q) || cmd_i.flush) begin
      out_byte_q     <= pend_byte_q;
      out_first_q    <= pend_first_q;
      out_last_q     <= pend_last_q;
      out_run_last_q <= cmd_i.flush;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign frame_first_o = out_first_q;
  assign frame_last_o  = out_last_q;
  assign run_last_o    = out_run_last_q;

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(HoldCap))
    else $error("buffer fill exceeds hold capacity");

  a_hold_in_buf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hc_q <= cnt_q)
    else $error("held count exceeds buffer fill");

  a_digits_after_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhDigits |-> mp_q == MpW'(PatLen))
    else $error("digit phase without full header match");

  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush |=> out_valid_q && out_run_last_q)
    else $error("flush did not present last result of run");

  a_rel_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rel_pop |-> hc_q != '0)
    else $error("release from empty hold");

endmodule

`default_nettype wire

// ===== test/fix_frame_splitter_tb.sv =====
`default_nettype none

module fix_frame_splitter_tb;
  import ffs_pkg::*;

  localparam int unsigned CycleLimit   = 500000;
  localparam int unsigned SettleCycles = 100;
  localparam int unsigned LongHold     = 300;
  localparam int unsigned MaxShown     = 10;
  localparam int unsigned PhaseBytes   = 32;
  localparam logic [7:0]  DigitZero    = 8'h30;
  localparam logic [7:0]  DigitNine    = 8'h39;

  // "8=FIX.4.4" SOH "9="
  localparam logic [7:0] FixHdr [PatLen] = '{
    8'h38, 8'h3D, 8'h46, 8'h49, 8'h58, 8'h2E, 8'h34, 8'h2E, 8'h34, Soh, 8'h39, 8'h3D
  };

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       run_end;
  } frame_beat_t;

  typedef enum int unsigned {
    SeqFrame, SeqZeros, SeqBroken, SeqOverCap, SeqEmptyLen, SeqBadDigit, SeqNoise
  } seq_kind_e;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [LenW-1:0] cfg_data_i  = '0;
  logic            in_valid_i  = 1'b0;
  logic            in_stall_o;
  logic [7:0]      in_byte_i   = 8'h00;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic [7:0]      out_byte_o;
  logic            frame_first_o;
  logic            frame_last_o;
  logic            run_last_o;

  // stimulus and expected frame bytes
  logic [7:0]  byte_q [$];
  frame_beat_t pending_beats [$];

  // deframer state as the testbench sees it
  logic [PhW-1:0]  scan_phase;
  int unsigned     hdr_pos, held_n, len_acc, body_left;
  logic [7:0]      held [HoldCap];
  logic [LenW-1:0] len_cap;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  logic        hold_on       = 1'b0;
  event        hold_ev;

  int unsigned cycle_n = 0;
  int unsigned bytes_queued = 0, bytes_taken = 0, beats_checked = 0, frames_seen = 0;
  int unsigned caps_written = 0, fail_n = 0;

  fix_frame_splitter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .frame_first_o(frame_first_o),
    .frame_last_o (frame_last_o),
    .run_last_o   (run_last_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic void clear_scan();
    scan_phase = PhHunt;
    hdr_pos    = 0;
    held_n     = 0;
    len_acc    = 0;
  endfunction

  // expected frame bytes for one received byte, including any rescans
  task automatic deframe_byte(input logic [7:0] in_b);
    logic [7:0]  work_q [$];
    logic [7:0]  redo_q [$];
    frame_beat_t run_q [$];
    logic [7:0]  b;
    logic        bad;
    int unsigned v;
    work_q.insert(work_q.size(), in_b);
    while (work_q.size() != 0) begin
      b = work_q[0];
      work_q.delete(0);
      bad = 1'b0;
      if (scan_phase == PhBody) begin
        // body and trailer pass straight through
        if (run_q.size() < MaxResults) begin
          run_q.insert(run_q.size(), frame_beat_t'{b, 1'b0, (body_left <= 1), 1'b0});
        end
        if (body_left <= 1) begin
          body_left = 0;
          clear_scan();
        end else begin
          body_left--;
        end
      end else if (scan_phase == PhHunt) begin
        if (hdr_pos < PatLen && b == FixHdr[hdr_pos] && held_n < HoldCap) begin
          held[held_n] = b;
          held_n++;
          hdr_pos++;
          if (hdr_pos == PatLen) begin
            scan_phase = PhDigits;
          end
        end else begin
          bad = 1'b1;
        end
      end else if (b == Soh) begin
        // closing SOH releases the whole held prefix
        if (held_n <= PatLen || held_n >= HoldCap) begin
          bad = 1'b1;
        end else begin
          held[held_n] = b;
          held_n++;
          for (int i = 0; i < held_n; i++) begin
            if (run_q.size() < MaxResults) begin
              run_q.insert(run_q.size(), frame_beat_t'{held[i], (i == 0), 1'b0, 1'b0});
            end
          end
          body_left  = len_acc + TrailerLen;
          scan_phase = PhBody;
          hdr_pos    = 0;
          held_n     = 0;
          len_acc    = 0;
        end
      end else if (b >= DigitZero && b <= DigitNine) begin
        v = len_acc * 10 + (b - DigitZero);
        if (v > len_cap || held_n + 1 >= HoldCap) begin
          bad = 1'b1;
        end else begin
          held[held_n] = b;
          held_n++;
          len_acc = v;
        end
      end else begin
        bad = 1'b1;
      end
      // resync: drop the first held byte, rescan the rest and this byte, or drop this byte if none is held
      if (bad) begin
        redo_q = {};
        if (held_n > 0) begin
          for (int i = 1; i < held_n; i++) begin
            redo_q.insert(redo_q.size(), held[i]);
          end
          redo_q.insert(redo_q.size(), b);
        end
        work_q = {redo_q, work_q};
        clear_scan();
      end
    end
    if (run_q.size() != 0) begin
      run_q[$].run_end = 1'b1;
    end
    foreach (run_q[i]) begin
      pending_beats.insert(pending_beats.size(), run_q[i]);
    end
  endtask

  // stimulus builders
  task automatic push_byte(input logic [7:0] b);
    byte_q.insert(byte_q.size(), b);
    bytes_queued++;
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i]);
    end
  endtask

  task automatic push_header(input int corrupt_at);
    for (int i = 0; i < PatLen; i++) begin
      push_byte((i == corrupt_at) ? 8'($urandom) : FixHdr[i]);
    end
  endtask

  task automatic push_body(input int unsigned len);
    repeat (len) push_byte(8'($urandom));
    push_str($sformatf("10=%03d", $urandom_range(255)));
    push_byte(Soh);
  endtask

  task automatic push_noise();
    repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
  endtask

  function automatic int unsigned pick_len();
    return $urandom_range(0, (len_cap < 14) ? len_cap : 14);
  endfunction

  task automatic push_seq(input seq_kind_e kind);
    int unsigned len, zeros;
    string       digits;
    logic [7:0]  junk;
    case (kind)
      SeqFrame, SeqBroken: begin
        len = pick_len();
        push_header((kind == SeqBroken) ? int'($urandom_range(PatLen - 1)) : -1);
        push_str($sformatf("%0d", len));
        push_byte(Soh);
        push_body(len);
      end
      SeqZeros: begin
        len = pick_len();
        digits = $sformatf("%0d", len);
        // twenty digits in all overflow the hold before the closing SOH
        if ($urandom_range(3) == 0) begin
          zeros = 20 - digits.len();
        end else begin
          zeros = $urandom_range(19 - digits.len());
        end
        push_header(-1);
        repeat (zeros) push_byte(DigitZero);
        push_str(digits);
        push_byte(Soh);
        push_body(len);
      end
      SeqOverCap: begin
        push_header(-1);
        push_str($sformatf("%0d", len_cap + 1 + $urandom_range(9)));
        push_byte(Soh);
        push_noise();
      end
      SeqEmptyLen: begin
        push_header(-1);
        push_byte(Soh);
        push_noise();
      end
      SeqBadDigit: begin
        push_header(-1);
        if ($urandom_range(1) == 1) begin
          push_byte(8'($urandom_range(DigitNine, DigitZero)));
        end
        do begin
          junk = 8'($urandom);
        end while ((junk >= DigitZero && junk <= DigitNine) || junk == Soh);
        push_byte(junk);
        push_noise();
      end
      default: begin
        push_noise();
      end
    endcase
  endtask

  task automatic push_random_seq();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) begin
      push_seq(SeqFrame);
    end else if (r < 60) begin
      push_seq(SeqZeros);
    end else if (r < 70) begin
      push_seq(SeqBroken);
    end else if (r < 78) begin
      push_seq(SeqOverCap);
    end else if (r < 84) begin
      push_seq(SeqEmptyLen);
    end else if (r < 90) begin
      push_seq(SeqBadDigit);
    end else begin
      push_seq(SeqNoise);
    end
  endtask

  // wait for every byte and frame byte, then let the block settle
  task automatic drain_and_settle();
    while (byte_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // cap register write, only while idle
  task automatic write_len_cap(input logic [LenW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    len_cap = (value > CapLimit) ? CapLimit : value;
    caps_written++;
  endtask

  task automatic run_phase(input logic [LenW-1:0] cap, input int unsigned idle_pct,
                           input int unsigned stall_in, input bit long_hold);
    int unsigned start;
    write_len_cap(cap);
    send_idle_pct = idle_pct;
    stall_pct     = stall_in;
    if (long_hold) begin
      @(negedge clk_i);
      -> hold_ev;
    end
    start = bytes_queued;
    while (bytes_queued - start < PhaseBytes) push_random_seq();
    drain_and_settle();
  endtask

  // sender: one pending byte offered at a time
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        deframe_byte(in_byte_i);
        bytes_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_byte_i  <= byte_q[0];
          byte_q.delete(0);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall, random or held off for a long stretch
  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= hold_on || ($urandom_range(99) < stall_pct);
    end
  end

  // long receiver hold, counted here
  always begin
    @(hold_ev);
    hold_on = 1'b1;
    repeat (LongHold) @(negedge clk_i);
    hold_on = 1'b0;
  end

  // compare each output transaction with the oldest expected frame byte
  always @(posedge clk_i) begin
    frame_beat_t seen, want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      seen = '{out_byte_o, frame_first_o, frame_last_o, run_last_o};
      beats_checked++;
      if (seen.last) begin
        frames_seen++;
      end
      if (pending_beats.size() == 0) begin
        fail_n++;
        if (fail_n <= MaxShown) begin
          $display("frame byte %0d: got %h first %b last %b run_last %b, none expected",
                   beats_checked, seen.data, seen.first, seen.last, seen.run_end);
        end
      end else begin
        want = pending_beats[0];
        pending_beats.delete(0);
        if (seen.data !== want.data || seen.first !== want.first ||
            seen.last !== want.last || seen.run_end !== want.run_end) begin
          fail_n++;
          if (fail_n <= MaxShown) begin
            $display("frame byte %0d: got %h first %b last %b run_last %b, want %h %b %b %b",
                     beats_checked, seen.data, seen.first, seen.last, seen.run_end,
                     want.data, want.first, want.last, want.run_end);
          end
        end
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_n < CycleLimit) begin
      @(posedge clk_i);
      cycle_n++;
    end
    $display("timeout after %0d cycles, %0d frame bytes outstanding",
             cycle_n, pending_beats.size());
    $display("[fix_frame_splitter] ERROR");
    $finish;
  end

  // main sequence
  initial begin
    clear_scan();
    body_left = 0;
    len_cap   = CapLimit;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero-length frame, only the trailer follows the prefix
    push_header(-1);
    push_str("0");
    push_byte(Soh);
    push_body(0);
    // stray bytes at both ends of the range with nothing held
    push_byte(8'h00);
    push_byte(8'hFF);
    // length one above the reset cap
    push_header(-1);
    push_str("1048577");
    push_byte(Soh);
    // length equal to the cap, then a non-digit
    push_header(-1);
    push_str("1048576");
    push_byte("x");
    // empty length
    push_header(-1);
    push_byte(Soh);
    // twenty zeros overflow the hold
    push_header(-1);
    repeat (20) push_byte(DigitZero);
    // nineteen zeros is the longest prefix that still fits
    push_header(-1);
    repeat (19) push_byte(DigitZero);
    push_byte(Soh);
    push_body(0);
    // wrong version in the header
    push_str("8=FIX.4.2");
    push_byte(Soh);
    // false start, header found again on the rescan
    push_str("8=");
    push_header(-1);
    push_str("3");
    push_byte(Soh);
    push_body(3);
    drain_and_settle();

    // random phases over cap settings and stall patterns
    run_phase(21'h1FFFFF, 0, 0, 1'b0);
    run_phase(21'd0, 61, 0, 1'b0);
    run_phase(21'd12, 0, 61, 1'b1);
    run_phase(CapLimit, 10, 10, 1'b0);
    run_phase(21'd5, 0, 0, 1'b0);

    fail_n += pending_beats.size();
    $display("covered %0d input bytes, %0d frame bytes checked, %0d frames closed",
             bytes_taken, beats_checked, frames_seen);
    $display("%0d cap writes incl. saturating and zero, four stall patterns, %0d failures",
             caps_written, fail_n);
    if (fail_n == 0) begin
      $display("[fix_frame_splitter] OK");
    end else begin
      $display("[fix_frame_splitter] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
